// ----- rtl/ordered_list_engine_core_defines.svh -----
// Assertion macros shared by the ordered list engine RTL.
// Expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ORDERED_LIST_ENGINE_CORE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define OLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define OLE_ASSERT(lbl, prop, msg)
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/olist_pkg.sv -----
// Shared types and constants for the ordered list engine.
// No dependencies; imported by the core.
package olist_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = 6;   // index width, matches position fields
  localparam int CNT_W    = 7;   // count width, holds CAPACITY itself
  localparam int DATA_W   = 32;

  localparam logic [2:0] MODE_PUSH   = 3'd0;
  localparam logic [2:0] MODE_POP    = 3'd1;
  localparam logic [2:0] MODE_INSERT = 3'd2;
  localparam logic [2:0] MODE_DELETE = 3'd3;
  localparam logic [2:0] MODE_REMOVE = 3'd4;
  localparam logic [2:0] MODE_FIND   = 3'd5;
  localparam logic [2:0] MODE_READ   = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [2:0]               mode;
    logic [IDX_W-1:0]         position_in;
    logic signed [DATA_W-1:0] value_in;
  } cmd_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] value_out;
    logic [IDX_W-1:0]         position_out;
    logic [CNT_W-1:0]         count_out;
  } result_t;

endpackage

// ----- rtl/olist_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module olist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ordered_list_engine_core.sv -----
// Ordered list engine top level: command FSM around one entry RAM.
// Depends on olist_pkg, olist_ram and ordered_list_engine_core_defines.svh.
//
// One command is taken when start is high and busy is low; its single result
// appears for exactly one cycle with done high and must be captured then, as
// the block cannot be held off. Push, mode 7, every rejected command, insert at
// the end of the list, delete of the last entry, and remove-all or find on an
// empty list finish in S_CHECK; pop and read also pass through S_WAIT_RD.
// Otherwise insert, delete, remove-all and find walk the entry RAM one read per
// cycle through its single read port, in S_SCAN. Delete walks the entries above
// position (count - position - 1 of them); remove-all walks all count entries;
// find walks up to and including the first match, or all count entries when
// nothing matches. Insert walks the count - position entries from the top down
// to position, then places the new value in S_INS_FIN.
`include "ordered_list_engine_core_defines.svh"

module ordered_list_engine_core
  import olist_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output result_t result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WAIT_RD,
    S_SCAN,
    S_INS_FIN
  } state_t;

  state_t           state;
  cmd_t             cmd_q;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] ptr;
  logic             iss;
  logic             vld_d;
  logic [IDX_W-1:0] idx_d;
  logic [CNT_W-1:0] j;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [DATA_W-1:0] rd_data;
  logic              issue;

  logic [CNT_W-1:0] count_m1;
  logic [CNT_W-1:0] count_p1;
  logic [CNT_W-1:0] pos_ext;
  logic             full;
  logic [IDX_W-1:0] last_idx;
  logic             hit;
  logic [CNT_W-1:0] j_next;

  function automatic result_t make_result(logic [2:0] st, logic [DATA_W-1:0] v,
                                          logic [IDX_W-1:0] p, logic [CNT_W-1:0] c);
    result_t r;
    r.status       = st;
    r.value_out    = v;
    r.position_out = p;
    r.count_out    = c;
    return r;
  endfunction

  assign busy     = (state != S_IDLE);
  assign count_m1 = count - CNT_W'(1);
  assign count_p1 = count + CNT_W'(1);
  assign pos_ext  = {1'b0, cmd_q.position_in};
  assign full     = (count == CNT_W'(CAPACITY));
  assign last_idx = (cmd_q.mode == MODE_INSERT) ? cmd_q.position_in : count_m1[IDX_W-1:0];
  assign hit      = (rd_data == cmd_q.value_in);
  assign j_next   = j + CNT_W'(!hit);

  olist_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // RAM port control, decoded from registered state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_d;
    mem_wdata = rd_data;
    mem_raddr = ptr;
    issue     = 1'b0;
    case (state)
      S_CHECK: begin
        case (cmd_q.mode)
          MODE_PUSH: begin
            mem_we    = !full;
            mem_waddr = count[IDX_W-1:0];
            mem_wdata = cmd_q.value_in;
          end
          MODE_POP:  mem_raddr = count_m1[IDX_W-1:0];
          MODE_READ: mem_raddr = cmd_q.position_in;
          MODE_INSERT: begin
            // append case: no shifting needed
            mem_we    = !full && (pos_ext == count);
            mem_waddr = cmd_q.position_in;
            mem_wdata = cmd_q.value_in;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        issue = iss;
        if (vld_d) begin
          case (cmd_q.mode)
            MODE_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = idx_d + IDX_W'(1);
            end
            MODE_DELETE: begin
              mem_we    = 1'b1;
              mem_waddr = idx_d - IDX_W'(1);
            end
            MODE_REMOVE: begin
              mem_we    = !hit;
              mem_waddr = j[IDX_W-1:0];
            end
            default: ;
          endcase
        end
      end
      S_INS_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = cmd_q.position_in;
        mem_wdata = cmd_q.value_in;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      count <= '0;
      iss   <= 1'b0;
      vld_d <= 1'b0;
    end else begin
      done  <= 1'b0;
      vld_d <= (state == S_SCAN) && iss;
      if (issue) begin
        idx_d <= ptr;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          case (cmd_q.mode)
            MODE_PUSH: begin
              done  <= 1'b1;
              state <= S_IDLE;
              if (full) begin
                result <= make_result(ST_FULL, '0, '0, count);
              end else begin
                count  <= count_p1;
                result <= make_result(ST_OK, '0, '0, count_p1);
              end
            end
            MODE_POP: begin
              if (count == '0) begin
                result <= make_result(ST_EMPTY, '0, '0, count);
                done   <= 1'b1;
                state  <= S_IDLE;
              end else begin
                count <= count_m1;
                state <= S_WAIT_RD;
              end
            end
            MODE_READ: begin
              if (pos_ext >= count) begin
                result <= make_result(ST_RANGE, '0, '0, count);
                done   <= 1'b1;
                state  <= S_IDLE;
              end else begin
                state <= S_WAIT_RD;
              end
            end
            MODE_INSERT: begin
              if (full || pos_ext > count) begin
                result <= make_result(full ? ST_FULL : ST_RANGE, '0, '0, count);
                done   <= 1'b1;
                state  <= S_IDLE;
              end else if (pos_ext == count) begin
                count  <= count_p1;
                result <= make_result(ST_OK, '0, '0, count_p1);
                done   <= 1'b1;
                state  <= S_IDLE;
              end else begin
                // shift up from the top entry down to position
                ptr   <= count_m1[IDX_W-1:0];
                iss   <= 1'b1;
                state <= S_SCAN;
              end
            end
            MODE_DELETE: begin
              if (pos_ext >= count) begin
                result <= make_result(ST_RANGE, '0, '0, count);
                done   <= 1'b1;
                state  <= S_IDLE;
              end else if (pos_ext == count_m1) begin
                count  <= count_m1;
                result <= make_result(ST_OK, '0, '0, count_m1);
                done   <= 1'b1;
                state  <= S_IDLE;
              end else begin
                ptr   <= cmd_q.position_in + IDX_W'(1);
                iss   <= 1'b1;
                state <= S_SCAN;
              end
            end
            MODE_REMOVE, MODE_FIND: begin
              if (count == '0) begin
                result <= make_result(ST_NOTFOUND, '0, '0, count);
                done   <= 1'b1;
                state  <= S_IDLE;
              end else begin
                ptr   <= '0;
                j     <= '0;
                iss   <= 1'b1;
                state <= S_SCAN;
              end
            end
            default: begin
              result <= make_result(ST_OK, '0, '0, count);
              done   <= 1'b1;
              state  <= S_IDLE;
            end
          endcase
        end
        S_WAIT_RD: begin
          result <= make_result(ST_OK, rd_data, '0, count);
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_SCAN: begin
          if (issue) begin
            if (ptr == last_idx) begin
              iss <= 1'b0;
            end else if (cmd_q.mode == MODE_INSERT) begin
              ptr <= ptr - IDX_W'(1);
            end else begin
              ptr <= ptr + IDX_W'(1);
            end
          end
          if (vld_d) begin
            case (cmd_q.mode)
              MODE_INSERT: begin
                if (idx_d == last_idx) begin
                  state <= S_INS_FIN;
                end
              end
              MODE_DELETE: begin
                if (idx_d == last_idx) begin
                  count  <= count_m1;
                  result <= make_result(ST_OK, '0, '0, count_m1);
                  done   <= 1'b1;
                  state  <= S_IDLE;
                end
              end
              MODE_REMOVE: begin
                j <= j_next;
                if (idx_d == last_idx) begin
                  count  <= j_next;
                  result <= make_result((j_next == count) ? ST_NOTFOUND : ST_OK,
                                        '0, '0, j_next);
                  done   <= 1'b1;
                  state  <= S_IDLE;
                end
              end
              MODE_FIND: begin
                if (hit) begin
                  iss    <= 1'b0;  // stop early; a read still in flight is dropped
                  result <= make_result(ST_OK, '0, idx_d, count);
                  done   <= 1'b1;
                  state  <= S_IDLE;
                end else if (idx_d == last_idx) begin
                  result <= make_result(ST_NOTFOUND, '0, '0, count);
                  done   <= 1'b1;
                  state  <= S_IDLE;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_INS_FIN: begin
          count  <= count_p1;
          result <= make_result(ST_OK, '0, '0, count_p1);
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `OLE_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY), "entry count beyond capacity")
  `OLE_ASSERT(a_no_rw_overlap, (issue && mem_we) |-> (mem_waddr != mem_raddr), "RAM address clash")
  `OLE_ASSERT(a_done_after_busy, done |-> $past(busy), "result strobe while idle")
  `OLE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")

endmodule
